// ----- hdl/lhs_pkg.sv -----
// ----------------------------------------------------------------------------
// lhs_pkg: shared types and constants for the latency histogram unit
// Item, result, configuration and decoded-command structs, op and CSR codes.
// ----------------------------------------------------------------------------
package lhs_pkg;

   // Widest bucket or log address over the supported depth range (up to 4096)
   localparam int ADDR_MAX_W = 12;

   // CSR indexes
   localparam logic [1:0] CSR_BUCKET_SHIFT   = 2'd0;
   localparam logic [1:0] CSR_BUCKETS_IN_USE = 2'd1;
   localparam logic [1:0] CSR_OUTLIER_LIMIT  = 2'd2;

   // CSR reset values
   localparam logic [4:0] RST_BUCKET_SHIFT   = 5'd3;
   localparam logic [7:0] RST_BUCKETS_IN_USE = 8'd125;
   localparam logic [6:0] RST_OUTLIER_LIMIT  = 7'd64;

   // Request functions
   typedef enum logic [1:0] {
      OP_ADD       = 2'd0,
      OP_RD_BUCKET = 2'd1,
      OP_RD_LOG    = 2'd2,
      OP_NONE      = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] value;
      logic [63:0] timestamp;
      logic [6:0]  index;
   } req_type;

   typedef struct packed {
      logic [63:0] sample_total;
      logic [63:0] value_total;
      logic [63:0] square_total;
      logic [31:0] least_seen;
      logic [31:0] greatest_seen;
      logic [63:0] outlier_total;
      logic [31:0] read_count;
      logic [63:0] read_time;
      logic        read_valid;
   } rsp_type;

   typedef struct packed {
      logic [4:0] bucket_shift;
      logic [7:0] buckets_in_use;
      logic [6:0] outlier_limit;
   } cfg_type;

   // Decoded item handed from the front end to the back end
   typedef struct packed {
      op_type                  op;
      logic [31:0]             value;
      logic [63:0]             timestamp;
      logic [ADDR_MAX_W-1:0]   bkt_addr;
      logic                    bkt_hit;
      logic                    is_outlier;
      logic                    log_we;
      logic [ADDR_MAX_W-1:0]   log_addr;
      logic                    rd_valid;
   } cmd_type;

endpackage

// ----- hdl/lhs_fifo.sv -----
// ----------------------------------------------------------------------------
// lhs_fifo: small synchronous queue
// Register-array queue with occupancy count; head entry shown while not empty.
// ----------------------------------------------------------------------------
module lhs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff,  count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign dout  = mem[rd_ptr_ff];

   // pointer and count next state
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= din;
      end
   end

endmodule

// ----- hdl/lhs_front.sv -----
// ----------------------------------------------------------------------------
// lhs_front: request classifier
// Decodes each accepted item: bucket slot and range check, outlier log slot,
// read range checks. Owns the count of logged outlier entries.
// ----------------------------------------------------------------------------
module lhs_front #(
   parameter int NUM_BUCKETS   = 128,
   parameter int OUTLIER_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  lhs_pkg::cfg_type cfg,
   input  lhs_pkg::req_type req,
   input  logic             accept,
   output lhs_pkg::cmd_type cmd
);

   localparam int AddrW = lhs_pkg::ADDR_MAX_W;
   localparam int LogCw = $clog2(OUTLIER_DEPTH + 1);

   logic [LogCw-1:0] log_cnt_ff, log_cnt_in;
   logic [31:0]      slot;
   logic             in_range;
   logic             log_room;
   logic [31:0]      idx32;

   // sample >> shift < buckets  <=>  sample < buckets << shift
   assign slot     = req.value >> cfg.bucket_shift;
   assign in_range = (slot < 32'(cfg.buckets_in_use)) && (slot < 32'(NUM_BUCKETS));
   assign log_room = (32'(log_cnt_ff) < 32'(cfg.outlier_limit)) &&
                     (32'(log_cnt_ff) < 32'(OUTLIER_DEPTH));
   assign idx32    = 32'(req.index);

   // decode
   always_comb begin
      cmd            = '0;
      cmd.op         = lhs_pkg::op_type'(req.func);
      cmd.value      = req.value;
      cmd.timestamp  = req.timestamp;
      unique case (cmd.op)
         lhs_pkg::OP_ADD: begin
            cmd.bkt_addr   = slot[AddrW-1:0];
            cmd.bkt_hit    = in_range;
            cmd.is_outlier = !in_range;
            cmd.log_we     = !in_range && log_room;
            cmd.log_addr   = AddrW'(log_cnt_ff);
         end
         lhs_pkg::OP_RD_BUCKET: begin
            cmd.bkt_addr = AddrW'(req.index);
            cmd.rd_valid = (idx32 < 32'(cfg.buckets_in_use)) && (idx32 < 32'(NUM_BUCKETS));
         end
         lhs_pkg::OP_RD_LOG: begin
            cmd.log_addr = AddrW'(req.index);
            cmd.rd_valid = idx32 < 32'(log_cnt_ff);
         end
         default: begin
            cmd.rd_valid = 1'b0;
         end
      endcase
   end

   // logged entry count
   assign log_cnt_in = (accept && cmd.log_we) ? log_cnt_ff + 1'b1 : log_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         log_cnt_ff <= '0;
      end else begin
         log_cnt_ff <= log_cnt_in;
      end
   end

   a_log_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      32'(log_cnt_ff) <= 32'(OUTLIER_DEPTH))
      else $error("logged entry count beyond log depth");

   a_log_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd.log_we) |=> (log_cnt_ff == $past(log_cnt_ff) + 1'b1))
      else $error("logged entry count missed an outlier write");

endmodule

// ----- hdl/lhs_back.sv -----
// ----------------------------------------------------------------------------
// lhs_back: statistics execution pipeline
// Two stages: stage 1 reads bucket and log memories, writes the outlier log
// and squares the sample; stage 2 does the bucket read-modify-write with
// forwarding, updates the running totals and emits the result item.
// Sweeps the bucket memory to zero after reset.
// ----------------------------------------------------------------------------
module lhs_back #(
   parameter int NUM_BUCKETS   = 128,
   parameter int OUTLIER_DEPTH = 64,
   parameter int COUNT_WIDTH   = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  lhs_pkg::cmd_type cmd,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output lhs_pkg::rsp_type rsp,
   output logic             clearing
);

   localparam int BktAw = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int LogAw = (OUTLIER_DEPTH > 1) ? $clog2(OUTLIER_DEPTH) : 1;

   logic [COUNT_WIDTH-1:0] bkt_mem      [NUM_BUCKETS];
   logic [31:0]            log_val_mem  [OUTLIER_DEPTH];
   logic [63:0]            log_time_mem [OUTLIER_DEPTH];

   // control
   logic                   clr_ff, clr_in;
   logic [BktAw-1:0]       clr_addr_ff, clr_addr_in;
   logic                   adv;
   logic                   s1_vld_ff, s1_vld_in;
   logic                   s2_vld_ff, s2_vld_in;
   logic                   fwd_vld_ff, fwd_vld_in;

   // payload
   lhs_pkg::cmd_type       s1_cmd_ff;
   lhs_pkg::cmd_type       s2_cmd_ff;
   logic [63:0]            s2_sq_ff;
   logic [COUNT_WIDTH-1:0] bkt_q_ff;
   logic [31:0]            log_val_q_ff;
   logic [63:0]            log_time_q_ff;
   logic [BktAw-1:0]       fwd_addr_ff;
   logic [COUNT_WIDTH-1:0] fwd_data_ff;

   // running totals
   logic [63:0] cnt_ff, cnt_in;
   logic [63:0] sum_ff, sum_in;
   logic [63:0] sqs_ff, sqs_in;
   logic [31:0] min_ff, min_in;
   logic [31:0] max_ff, max_in;
   logic [63:0] outl_ff, outl_in;

   logic [BktAw-1:0]       s1_bkt_addr, s2_bkt_addr, bkt_wa;
   logic [LogAw-1:0]       s1_log_addr;
   logic [63:0]            s1_sq;
   logic                   log_we;
   logic [COUNT_WIDTH-1:0] cur_cnt, inc_cnt, bkt_wd;
   logic                   upd_we, bkt_we;
   logic                   is_add, tot_upd;
   logic [63:0]            cur_wide;

   assign clearing = clr_ff;
   assign adv      = !clr_ff && !rsp_full;
   assign cmd_pop  = adv && !cmd_empty;
   assign rsp_push = adv && s2_vld_ff;

   // clearing sweep after reset
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == BktAw'(NUM_BUCKETS - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   // stage valids
   assign s1_vld_in = adv ? cmd_pop   : s1_vld_ff;
   assign s2_vld_in = adv ? s1_vld_ff : s2_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         fwd_vld_ff  <= 1'b0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
         s1_vld_ff   <= s1_vld_in;
         s2_vld_ff   <= s2_vld_in;
         fwd_vld_ff  <= fwd_vld_in;
      end
   end

   // stage 1: addresses, square, log write
   assign s1_bkt_addr = s1_cmd_ff.bkt_addr[BktAw-1:0];
   assign s1_log_addr = s1_cmd_ff.log_addr[LogAw-1:0];
   assign s1_sq       = 64'(s1_cmd_ff.value) * 64'(s1_cmd_ff.value);
   assign log_we      = adv && s1_vld_ff && s1_cmd_ff.log_we;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cmd_ff <= cmd;
         s2_cmd_ff <= s1_cmd_ff;
         s2_sq_ff  <= s1_sq;
      end
   end

   // outlier log memory
   always_ff @(posedge clock) begin
      if (log_we) begin
         log_val_mem[s1_log_addr]  <= s1_cmd_ff.value;
         log_time_mem[s1_log_addr] <= s1_cmd_ff.timestamp;
      end
      if (adv) begin
         log_val_q_ff  <= log_val_mem[s1_log_addr];
         log_time_q_ff <= log_time_mem[s1_log_addr];
      end
   end

   // stage 2: bucket read-modify-write, forward last write over stale read
   assign s2_bkt_addr = s2_cmd_ff.bkt_addr[BktAw-1:0];
   assign cur_cnt     = (fwd_vld_ff && (fwd_addr_ff == s2_bkt_addr)) ? fwd_data_ff : bkt_q_ff;
   assign inc_cnt     = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;
   assign is_add      = s2_vld_ff && (s2_cmd_ff.op == lhs_pkg::OP_ADD);
   assign tot_upd     = adv && is_add;
   assign upd_we      = tot_upd && s2_cmd_ff.bkt_hit;
   assign fwd_vld_in  = adv ? upd_we : fwd_vld_ff;

   assign bkt_we = clr_ff || upd_we;
   assign bkt_wa = clr_ff ? clr_addr_ff : s2_bkt_addr;
   assign bkt_wd = clr_ff ? '0 : inc_cnt;

   // bucket memory
   always_ff @(posedge clock) begin
      if (bkt_we) begin
         bkt_mem[bkt_wa] <= bkt_wd;
      end
      if (adv) begin
         bkt_q_ff <= bkt_mem[s1_bkt_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (upd_we) begin
         fwd_addr_ff <= s2_bkt_addr;
         fwd_data_ff <= inc_cnt;
      end
   end

   // running totals
   always_comb begin
      cnt_in  = cnt_ff + 64'd1;
      sum_in  = sum_ff + 64'(s2_cmd_ff.value);
      sqs_in  = sqs_ff + s2_sq_ff;
      min_in  = (s2_cmd_ff.value < min_ff) ? s2_cmd_ff.value : min_ff;
      max_in  = (s2_cmd_ff.value > max_ff) ? s2_cmd_ff.value : max_ff;
      outl_in = s2_cmd_ff.is_outlier ? outl_ff + 64'd1 : outl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         sum_ff  <= '0;
         sqs_ff  <= '0;
         min_ff  <= '1;
         max_ff  <= '0;
         outl_ff <= '0;
      end else if (tot_upd) begin
         cnt_ff  <= cnt_in;
         sum_ff  <= sum_in;
         sqs_ff  <= sqs_in;
         min_ff  <= min_in;
         max_ff  <= max_in;
         outl_ff <= outl_in;
      end
   end

   // result item: totals as they stand after this item
   assign cur_wide = 64'(cur_cnt);

   always_comb begin
      rsp               = '0;
      rsp.sample_total  = is_add ? cnt_in  : cnt_ff;
      rsp.value_total   = is_add ? sum_in  : sum_ff;
      rsp.square_total  = is_add ? sqs_in  : sqs_ff;
      rsp.least_seen    = is_add ? min_in  : min_ff;
      rsp.greatest_seen = is_add ? max_in  : max_ff;
      rsp.outlier_total = is_add ? outl_in : outl_ff;
      case (s2_cmd_ff.op)
         lhs_pkg::OP_RD_BUCKET: begin
            if (s2_cmd_ff.rd_valid) begin
               rsp.read_count = (cur_wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                     : cur_wide[31:0];
               rsp.read_valid = 1'b1;
            end
         end
         lhs_pkg::OP_RD_LOG: begin
            if (s2_cmd_ff.rd_valid) begin
               rsp.read_count = log_val_q_ff;
               rsp.read_time  = log_time_q_ff;
               rsp.read_valid = 1'b1;
            end
         end
         default: begin
            rsp.read_valid = 1'b0;
         end
      endcase
   end

   a_no_pop_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> (!cmd_pop && !upd_we && !log_we))
      else $error("item traffic during bucket clear");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into full queue");

   a_fwd_on_write: assert property (@(posedge clock) disable iff (reset)
      upd_we |=> (fwd_vld_ff && (fwd_addr_ff == $past(s2_bkt_addr))))
      else $error("bucket write not captured for forwarding");

endmodule

// ----- hdl/latency_histogram_stats_unit.sv -----
// ----------------------------------------------------------------------------
// latency_histogram_stats_unit: latency histogram with outlier log
// Running count, sum, sum of squares, min and max of latency samples, a
// bucket histogram with saturating counts and a log of outlier samples.
//
// Request queue: present an item with req_push; it is taken at an edge where
//   req_full is low. func selects add sample, read bucket, read log entry or none.
// Result queue: while rsp_empty is low the oldest result sits on rsp_item;
//   rsp_pop takes it. Every request yields exactly one result.
// CSR port: csr_we writes csr_wdata to register csr_addr; write
//   only while no request is in flight.
// Throughput: one item per cycle while the result queue has room, reads and
//   writes to one bucket back to back (stage 2 forwards its last bucket write).
// Path: an accepted item passes the request queue, the memory read stage,
//   the update stage and the result queue before its result shows on rsp_item.
// Stalls: results wait in a 4-entry queue; when it fills, the pipeline holds
//   and the 4-entry request queue absorbs new items before req_full rises.
// Reset: totals clear, min goes to all ones; the bucket memory is then swept
//   to zero, with req_full held high meanwhile.
// ----------------------------------------------------------------------------
module latency_histogram_stats_unit #(
   parameter int NUM_BUCKETS   = 128,
   parameter int OUTLIER_DEPTH = 64,
   parameter int COUNT_WIDTH   = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  lhs_pkg::req_type req_item,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output lhs_pkg::rsp_type rsp_item,
   input  logic             csr_we,
   input  logic [1:0]       csr_addr,
   input  logic [7:0]       csr_wdata
);

   localparam int QueueDepth = 4;

   lhs_pkg::cfg_type cfg_ff, cfg_in;
   lhs_pkg::cmd_type front_cmd, back_cmd;
   lhs_pkg::rsp_type back_rsp;
   logic             accept;
   logic             cmd_full, cmd_empty, cmd_pop;
   logic             rsp_full, rsp_push;
   logic             clearing;

   // CSR writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            lhs_pkg::CSR_BUCKET_SHIFT:   cfg_in.bucket_shift   = csr_wdata[4:0];
            lhs_pkg::CSR_BUCKETS_IN_USE: cfg_in.buckets_in_use = csr_wdata;
            lhs_pkg::CSR_OUTLIER_LIMIT:  cfg_in.outlier_limit  = csr_wdata[6:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bucket_shift   <= lhs_pkg::RST_BUCKET_SHIFT;
         cfg_ff.buckets_in_use <= lhs_pkg::RST_BUCKETS_IN_USE;
         cfg_ff.outlier_limit  <= lhs_pkg::RST_OUTLIER_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request acceptance
   assign req_full = cmd_full || clearing;
   assign accept   = req_push && !req_full;

   lhs_front #(
      .NUM_BUCKETS   (NUM_BUCKETS),
      .OUTLIER_DEPTH (OUTLIER_DEPTH)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req    (req_item),
      .accept (accept),
      .cmd    (front_cmd)
   );

   lhs_fifo #(
      .WIDTH ($bits(lhs_pkg::cmd_type)),
      .DEPTH (QueueDepth)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (accept),
      .din   (front_cmd),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .dout  (back_cmd),
      .empty (cmd_empty)
   );

   lhs_back #(
      .NUM_BUCKETS   (NUM_BUCKETS),
      .OUTLIER_DEPTH (OUTLIER_DEPTH),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (back_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (back_rsp),
      .clearing  (clearing)
   );

   lhs_fifo #(
      .WIDTH ($bits(lhs_pkg::rsp_type)),
      .DEPTH (QueueDepth)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (back_rsp),
      .full  (rsp_full),
      .pop   (rsp_pop && !rsp_empty),
      .dout  (rsp_item),
      .empty (rsp_empty)
   );

endmodule

// ----- tb/lhs_stats_checker.sv -----
// ----------------------------------------------------------------------------
// lhs_stats_checker: result predictor and scoreboard for the latency histogram
// Watches the request, result and CSR ports, keeps its own copy of the
// totals, bucket counts and outlier log, predicts one result per accepted
// item and compares every popped result field by field, in order.
// ----------------------------------------------------------------------------
module lhs_stats_checker #(
   parameter int NUM_BUCKETS   = 128,
   parameter int OUTLIER_DEPTH = 64,
   parameter int COUNT_WIDTH   = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic                req_full,
   input  lhs_pkg::req_type    req_item,
   input  logic                rsp_empty,
   input  logic                rsp_pop,
   input  lhs_pkg::rsp_type    rsp_item,
   input  logic                csr_we,
   input  logic [1:0]          csr_addr,
   input  logic [7:0]          csr_wdata,
   output int unsigned         fail_count,
   output int unsigned         results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] COUNT_MAX = {64{1'b1}} >> (64 - COUNT_WIDTH);
   localparam int BktAw = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int LogAw = (OUTLIER_DEPTH > 1) ? $clog2(OUTLIER_DEPTH) : 1;

   // Register copies
   logic [4:0]  shift_cfg;
   logic [7:0]  buckets_cfg;
   logic [6:0]  limit_cfg;

   // Running totals
   logic [63:0] samples_seen;
   logic [63:0] value_acc;
   logic [63:0] square_acc;
   logic [31:0] least_acc;
   logic [31:0] greatest_acc;
   logic [63:0] outliers_seen;

   // Histogram and outlier log
   logic [63:0] bucket_count [NUM_BUCKETS];
   logic [31:0] log_value [OUTLIER_DEPTH];
   logic [63:0] log_time [OUTLIER_DEPTH];
   int unsigned log_used;

   lhs_pkg::rsp_type expected_stats_q [$];

   initial begin
      fail_count      = 0;
      results_pending = 0;
   end

   function automatic int unsigned buckets_active();
      return (buckets_cfg > NUM_BUCKETS) ? NUM_BUCKETS : 32'(buckets_cfg);
   endfunction

   function automatic int unsigned limit_active();
      return (limit_cfg > OUTLIER_DEPTH) ? OUTLIER_DEPTH : 32'(limit_cfg);
   endfunction

   // Fold one sample into totals, then into a bucket or the outlier log
   task automatic record_sample(input logic [31:0] v, input logic [63:0] ts);
      logic [63:0] wide;
      logic [63:0] bound;
      logic [63:0] slot;
      wide  = {32'd0, v};
      bound = 64'(buckets_active()) << shift_cfg;
      samples_seen += 64'd1;
      value_acc    += wide;
      square_acc   += wide * wide;
      if (v > greatest_acc) greatest_acc = v;
      if (v < least_acc) least_acc = v;
      if (wide < bound) begin
         slot = wide >> shift_cfg;
         if (bucket_count[slot[BktAw-1:0]] < COUNT_MAX)
            bucket_count[slot[BktAw-1:0]] += 64'd1;
      end else begin
         if (log_used < limit_active()) begin
            log_value[LogAw'(log_used)] = v;
            log_time[LogAw'(log_used)]  = ts;
            log_used++;
         end
         outliers_seen += 64'd1;
      end
   endtask

   // Expected result of one request, state updated on the way
   task automatic predict_stats(input lhs_pkg::req_type rq, output lhs_pkg::rsp_type rs);
      rs = '0;
      case (lhs_pkg::op_type'(rq.func))
         lhs_pkg::OP_ADD: begin
            record_sample(rq.value, rq.timestamp);
         end
         lhs_pkg::OP_RD_BUCKET: begin
            if (rq.index < buckets_active()) begin
               rs.read_count = (bucket_count[BktAw'(rq.index)] > 64'hFFFF_FFFF) ?
                               32'hFFFF_FFFF : bucket_count[BktAw'(rq.index)][31:0];
               rs.read_valid = 1'b1;
            end
         end
         lhs_pkg::OP_RD_LOG: begin
            if (rq.index < log_used) begin
               rs.read_count = log_value[LogAw'(rq.index)];
               rs.read_time  = log_time[LogAw'(rq.index)];
               rs.read_valid = 1'b1;
            end
         end
         default: ;
      endcase
      rs.sample_total  = samples_seen;
      rs.value_total   = value_acc;
      rs.square_total  = square_acc;
      rs.least_seen    = least_acc;
      rs.greatest_seen = greatest_acc;
      rs.outlier_total = outliers_seen;
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      lhs_pkg::rsp_type want;
      if (reset) begin
         shift_cfg     = lhs_pkg::RST_BUCKET_SHIFT;
         buckets_cfg   = lhs_pkg::RST_BUCKETS_IN_USE;
         limit_cfg     = lhs_pkg::RST_OUTLIER_LIMIT;
         samples_seen  = '0;
         value_acc     = '0;
         square_acc    = '0;
         least_acc     = '1;
         greatest_acc  = '0;
         outliers_seen = '0;
         log_used      = 0;
         for (int i = 0; i < NUM_BUCKETS; i++) bucket_count[i] = '0;
         expected_stats_q.delete();
         results_pending = 0;
      end else begin
         // CSR writes
         if (csr_we) begin
            case (csr_addr)
               lhs_pkg::CSR_BUCKET_SHIFT:   shift_cfg   = csr_wdata[4:0];
               lhs_pkg::CSR_BUCKETS_IN_USE: buckets_cfg = csr_wdata[7:0];
               lhs_pkg::CSR_OUTLIER_LIMIT:  limit_cfg   = csr_wdata[6:0];
               default: ;
            endcase
         end
         // Popped result against the oldest expectation
         if (rsp_pop && !rsp_empty) begin
            if (expected_stats_q.size() == 0) begin
               $display("%0t: result with no item outstanding: expected none, got %0h",
                        $time, rsp_item);
               fail_count++;
            end else begin
               want = expected_stats_q.pop_front();
               check_field("sample_total", want.sample_total, rsp_item.sample_total);
               check_field("value_total", want.value_total, rsp_item.value_total);
               check_field("square_total", want.square_total, rsp_item.square_total);
               check_field("least_seen", want.least_seen, rsp_item.least_seen);
               check_field("greatest_seen", want.greatest_seen, rsp_item.greatest_seen);
               check_field("outlier_total", want.outlier_total, rsp_item.outlier_total);
               check_field("read_count", want.read_count, rsp_item.read_count);
               check_field("read_time", want.read_time, rsp_item.read_time);
               check_field("read_valid", want.read_valid, rsp_item.read_valid);
            end
         end
         // Accepted item
         if (req_push && !req_full) begin
            predict_stats(req_item, want);
            expected_stats_q.push_back(want);
         end
         results_pending = expected_stats_q.size();
      end
   end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for latency_histogram_stats_unit
// Directed items hit range edges, every function and the forwarding cases;
// random phases then run under several register settings with random gaps
// on both queues and long result stalls that back up the request queue.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BUCKETS    = 128;
   localparam int OUTLIER_DEPTH  = 64;
   localparam int COUNT_WIDTH    = 32;
   localparam int PHASES         = 7;
   localparam int PHASE_ITEMS    = 185;
   localparam int DRAIN_CYCLES   = 10;
   localparam int CYCLE_LIMIT    = 500000;

   logic             clock;
   logic             reset;
   logic             req_push;
   lhs_pkg::req_type req_item;
   logic             req_full;
   logic             rsp_empty;
   logic             rsp_pop;
   lhs_pkg::rsp_type rsp_item;
   logic             csr_we;
   logic [1:0]       csr_addr;
   logic [7:0]       csr_wdata;

   int unsigned fail_count;
   int unsigned results_pending;
   int unsigned cycle_count;
   bit          no_gaps;

   // Stimulus-side copy of the settings, used only to shape sample values and bucket read indexes
   int unsigned cfg_shift;
   int unsigned cfg_buckets;

   // Per-phase settings: extremes, zero buckets, oversize buckets and limits
   int unsigned phase_shift   [PHASES] = '{0, 16, 5, 2, 9, 4, 3};
   int unsigned phase_buckets [PHASES] = '{1, 128, 0, 255, 200, 64, 17};
   int unsigned phase_limit   [PHASES] = '{0, 10, 5, 127, 100, 64, 40};

   latency_histogram_stats_unit #(
      .NUM_BUCKETS   (NUM_BUCKETS),
      .OUTLIER_DEPTH (OUTLIER_DEPTH),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   lhs_stats_checker #(
      .NUM_BUCKETS   (NUM_BUCKETS),
      .OUTLIER_DEPTH (OUTLIER_DEPTH),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_item        (req_item),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_item        (rsp_item),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result side: random pops, two long holds to fill the block up
   initial begin : pop_driver
      int unsigned stall_left;
      int unsigned popped;
      bit          first_hold;
      bit          second_hold;
      int          r;
      stall_left  = 0;
      popped      = 0;
      first_hold  = 1'b0;
      second_hold = 1'b0;
      rsp_pop     = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) popped++;
         @(negedge clock);
         if (!first_hold && popped >= 200) begin
            first_hold = 1'b1;
            stall_left = 150;
         end else if (!second_hold && popped >= 700) begin
            second_hold = 1'b1;
            stall_left  = 150;
         end
         if (stall_left > 0) begin
            rsp_pop <= 1'b0;
            stall_left--;
         end else begin
            rsp_pop <= 1'b1;
            if (!no_gaps) begin
               r = $urandom_range(99);
               if (r < 15) stall_left = $urandom_range(1, 3);
               else if (r < 18) stall_left = $urandom_range(12, 40);
            end
         end
      end
   end

   function automatic lhs_pkg::req_type make_item(input lhs_pkg::op_type op,
                                                  input logic [31:0] value,
                                                  input logic [63:0] ts,
                                                  input logic [6:0] index);
      lhs_pkg::req_type it;
      it.func      = op;
      it.value     = value;
      it.timestamp = ts;
      it.index     = index;
      return it;
   endfunction

   // Random item, weighted toward adds near the bucket/outlier boundary
   function automatic lhs_pkg::req_type random_item();
      lhs_pkg::req_type it;
      int               r;
      int unsigned      nb;
      logic [63:0]      bound;
      it.func      = 2'($urandom);
      it.value     = $urandom;
      it.timestamp = {$urandom, $urandom};
      it.index     = 7'($urandom);
      nb    = (cfg_buckets > NUM_BUCKETS) ? NUM_BUCKETS : cfg_buckets;
      bound = 64'(nb) << cfg_shift;
      r     = $urandom_range(99);
      if (r < 55) begin
         it.func = lhs_pkg::OP_ADD;
         if (bound != 0) begin
            r = $urandom_range(9);
            if (r < 5) it.value = $urandom_range(0, 32'(bound - 1));
            else if (r < 7) it.value = 32'(bound) + $urandom_range(0, 32'(bound >> 2));
            else if (r == 7) it.value = 32'(bound - 1) + $urandom_range(0, 2);
         end
      end else if (r < 75) begin
         it.func = lhs_pkg::OP_RD_BUCKET;
         if (nb > 0 && $urandom_range(3) != 0) it.index = 7'($urandom_range(0, nb - 1));
      end else if (r < 92) begin
         it.func = lhs_pkg::OP_RD_LOG;
         if ($urandom_range(3) != 0) it.index = 7'($urandom_range(0, 70));
      end else if (r < 96) begin
         it.func = lhs_pkg::OP_NONE;
      end
      return it;
   endfunction

   // Offer one item after an optional gap; returns at the negedge after acceptance
   task automatic send_item(input lhs_pkg::req_type it);
      int unsigned gap;
      int          r;
      gap = 0;
      if (!no_gaps) begin
         r = $urandom_range(99);
         if (r < 20) gap = $urandom_range(1, 3);
         else if (r < 23) gap = $urandom_range(12, 40);
      end
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   // Stop offering and wait until every result is back
   task automatic wait_idle();
      req_push <= 1'b0;
      do @(negedge clock); while (results_pending != 0);
   endtask

   task automatic write_reg(input logic [1:0] addr, input logic [7:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic configure(input int unsigned shift, input int unsigned buckets,
                            input int unsigned limit);
      wait_idle();
      write_reg(lhs_pkg::CSR_BUCKET_SHIFT, 8'(shift));
      write_reg(lhs_pkg::CSR_BUCKETS_IN_USE, 8'(buckets));
      write_reg(lhs_pkg::CSR_OUTLIER_LIMIT, 8'(limit));
      csr_we      <= 1'b0;
      cfg_shift   = shift;
      cfg_buckets = buckets;
   endtask

   initial begin : stimulus
      req_push    = 1'b0;
      req_item    = '0;
      csr_we      = 1'b0;
      csr_addr    = '0;
      csr_wdata   = '0;
      no_gaps     = 1'b0;
      cfg_shift   = 32'(lhs_pkg::RST_BUCKET_SHIFT);
      cfg_buckets = 32'(lhs_pkg::RST_BUCKETS_IN_USE);
      reset       = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // wait for the bucket clear sweep
      do @(negedge clock); while (req_full);

      // Directed: reset settings, bucket bound is 125 << 3 = 1000
      send_item(make_item(lhs_pkg::OP_RD_BUCKET, '1, '1, 7'd0));
      send_item(make_item(lhs_pkg::OP_RD_LOG, '0, '0, 7'd0));
      send_item(make_item(lhs_pkg::OP_NONE, '1, '1, 7'd127));
      send_item(make_item(lhs_pkg::OP_ADD, 32'd0, 64'd0, 7'd0));
      send_item(make_item(lhs_pkg::OP_ADD, 32'd7, 64'd1, 7'd0));
      send_item(make_item(lhs_pkg::OP_RD_BUCKET, '0, '0, 7'd0));
      send_item(make_item(lhs_pkg::OP_ADD, 32'd8, 64'd2, 7'd0));
      send_item(make_item(lhs_pkg::OP_RD_BUCKET, '0, '0, 7'd1));
      send_item(make_item(lhs_pkg::OP_ADD, 32'd999, 64'd3, 7'd0));
      send_item(make_item(lhs_pkg::OP_RD_BUCKET, '0, '0, 7'd124));
      // first outlier at the exact bound
      send_item(make_item(lhs_pkg::OP_ADD, 32'd1000, 64'h8000_0000_0000_0000, 7'd0));
      send_item(make_item(lhs_pkg::OP_RD_BUCKET, '0, '0, 7'd125));
      send_item(make_item(lhs_pkg::OP_RD_BUCKET, '0, '0, 7'd127));
      // largest samples: square sum wraps
      send_item(make_item(lhs_pkg::OP_ADD, '1, '1, 7'd127));
      send_item(make_item(lhs_pkg::OP_ADD, '1, 64'h0123_4567_89AB_CDEF, 7'd0));
      send_item(make_item(lhs_pkg::OP_RD_LOG, '0, '0, 7'd0));
      send_item(make_item(lhs_pkg::OP_RD_LOG, '0, '0, 7'd1));
      send_item(make_item(lhs_pkg::OP_RD_LOG, '0, '0, 7'd2));
      send_item(make_item(lhs_pkg::OP_RD_LOG, '0, '0, 7'd3));
      send_item(make_item(lhs_pkg::OP_RD_LOG, '1, '1, 7'd127));
      send_item(make_item(lhs_pkg::OP_ADD, 32'd1, 64'd5, 7'd0));
      send_item(make_item(lhs_pkg::OP_RD_BUCKET, '1, '1, 7'd0));

      // Random phases under different settings
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1)
            configure($urandom_range(0, 16), $urandom_range(1, 128), $urandom_range(0, 64));
         else
            configure(phase_shift[p], phase_buckets[p], phase_limit[p]);
         no_gaps = (p % 3 == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
      end
      no_gaps = 1'b0;

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/lhs_pkg.sv
hdl/lhs_fifo.sv
hdl/lhs_front.sv
hdl/lhs_back.sv
hdl/latency_histogram_stats_unit.sv
tb/lhs_stats_checker.sv
tb/testbench.sv
